// File: design/timer_counter_8bit_pwm_unit_assert.svh
// assertion macros for the timer/counter pwm unit
`ifndef TIMER_COUNTER_8BIT_PWM_UNIT_ASSERT_SVH
`define TIMER_COUNTER_8BIT_PWM_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk with arst_n low as disable
`define TC8_ASSERT_SAME(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TC8_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tc8pwm_pkg.sv
// types, codes and helper functions shared by the timer/counter pwm unit
package tc8pwm_pkg;

	localparam int unsigned PrescWidth = 10;

	// request types
	localparam logic [1:0] ReqTick  = 2'd0;
	localparam logic [1:0] ReqWrite = 2'd1;
	localparam logic [1:0] ReqRead  = 2'd2;
	localparam logic [1:0] ReqAck   = 2'd3;

	// register addresses
	localparam logic [2:0] AddrCount   = 3'd0;
	localparam logic [2:0] AddrCompare = 3'd1;
	localparam logic [2:0] AddrEnables = 3'd2;
	localparam logic [2:0] AddrFlags   = 3'd3;
	localparam logic [2:0] AddrPeriod  = 3'd4;

	// acknowledge targets
	localparam logic [2:0] AckOverflow = 3'd0;
	localparam logic [2:0] AckCompare  = 3'd1;

	// waveform modes
	localparam logic [1:0] WaveNormal   = 2'd0;
	localparam logic [1:0] WavePhasePwm = 2'd1;
	localparam logic [1:0] WaveCtc      = 2'd2;
	localparam logic [1:0] WaveFastPwm  = 2'd3;

	// compare output modes
	localparam logic [1:0] OutOff    = 2'd0;
	localparam logic [1:0] OutToggle = 2'd1;
	localparam logic [1:0] OutClear  = 2'd2;
	localparam logic [1:0] OutSet    = 2'd3;

	// clock select codes
	localparam logic [2:0] ClkStop    = 3'd0;
	localparam logic [2:0] ClkDiv1    = 3'd1;
	localparam logic [2:0] ClkDiv8    = 3'd2;
	localparam logic [2:0] ClkDiv64   = 3'd3;
	localparam logic [2:0] ClkDiv256  = 3'd4;
	localparam logic [2:0] ClkDiv1024 = 3'd5;
	localparam logic [2:0] ClkPinFall = 3'd6;
	localparam logic [2:0] ClkPinRise = 3'd7;

	// configuration register indexes
	localparam logic [1:0] CfgWaveMode   = 2'd0;
	localparam logic [1:0] CfgOutputMode = 2'd1;
	localparam logic [1:0] CfgClockSel   = 2'd2;
	localparam logic [1:0] CfgPeriodTrk  = 2'd3;

	localparam logic [1:0] FlagOvf = 2'b01;
	localparam logic [1:0] FlagCmp = 2'b10;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] reg_addr;
		logic [7:0] write_data;
		logic       ext_pin;
	} item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        wave_out;
		logic        irq;
		logic [1:0]  flags_now;
	} result_t;

	typedef struct packed {
		logic [1:0] waveform_mode;
		logic [1:0] output_mode;
		logic [2:0] clock_select;
		logic       period_tracking;
	} cfg_t;

	typedef struct packed {
		logic [1:0] flags;
		logic [1:0] enables;
	} status_t;

	function automatic logic [PrescWidth-1:0] presc_mask(input logic [2:0] sel);
		logic [PrescWidth-1:0] m;
		unique case (sel)
			ClkDiv1:    m = 10'd0;
			ClkDiv8:    m = 10'd7;
			ClkDiv64:   m = 10'd63;
			ClkDiv256:  m = 10'd255;
			ClkDiv1024: m = 10'd1023;
			default:    m = 10'd0;
		endcase
		return m;
	endfunction

	function automatic logic pin_action(input logic cur, input logic [1:0] act);
		logic r;
		unique case (act)
			OutToggle: r = ~cur;
			OutClear:  r = 1'b0;
			OutSet:    r = 1'b1;
			default:   r = cur;
		endcase
		return r;
	endfunction

endpackage

// File: design/tc8pwm_if.sv
// valid/ready channel carrying one input item of the timer/counter pwm unit
interface tc8pwm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [2:0] reg_addr;
	logic [7:0] write_data;
	logic       ext_pin;

	modport source (output valid, output req_type, output reg_addr, output write_data,
		output ext_pin, input ready);
	modport sink (input valid, input req_type, input reg_addr, input write_data,
		input ext_pin, output ready);
endinterface

// valid/ready channel carrying one result item
interface tc8pwm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        wave_out;
	logic        irq;
	logic [1:0]  flags_now;

	modport source (output valid, output read_data, output wave_out, output irq,
		output flags_now, input ready);
	modport sink (input valid, input read_data, input wave_out, input irq,
		input flags_now, output ready);
endinterface

// File: design/tc8pwm_core.sv
// timer state, prescaler, waveform generation and register access for one item
module tc8pwm_core #(
	parameter int unsigned COUNT_WIDTH        = 8,
	parameter int unsigned PERIOD_COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  tc8pwm_pkg::item_t   item,
	input  tc8pwm_pkg::cfg_t    cfg,
	output tc8pwm_pkg::result_t result,
	output tc8pwm_pkg::status_t status
);

	localparam int unsigned PW = tc8pwm_pkg::PrescWidth;
	localparam logic [COUNT_WIDTH-1:0] CntMax = '1;
	localparam logic [COUNT_WIDTH-1:0] CntZero = '0;
	localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

	logic [COUNT_WIDTH-1:0]        cnt_q, cmp_act_q, cmp_buf_q;
	logic [PW-1:0]                 presc_q;
	logic                          down_q, wave_q, last_pin_q;
	logic [1:0]                    flags_q, en_q;
	logic [PERIOD_COUNT_WIDTH-1:0] per_q;

	logic [COUNT_WIDTH-1:0]        cnt_d, cmp_act_d, cmp_buf_d;
	logic [PW-1:0]                 presc_d;
	logic                          down_d, wave_d, last_pin_d;
	logic [1:0]                    flags_d, en_d;
	logic [PERIOD_COUNT_WIDTH-1:0] per_d;
	logic [15:0]                   rd;

	logic                          fire, match, rising;
	logic [PW-1:0]                 mask;
	logic [1:0]                    ack_bit;
	logic [31:0]                   per_wide;

	assign mask     = tc8pwm_pkg::presc_mask(cfg.clock_select);
	assign per_wide = 32'(per_q);
	assign match    = (cnt_q == cmp_act_q);
	assign rising   = (cnt_q == CntZero) || (!down_q && cnt_q != CntMax);
	assign ack_bit  = (item.reg_addr == tc8pwm_pkg::AckOverflow) ?
		tc8pwm_pkg::FlagOvf : tc8pwm_pkg::FlagCmp;

	always_comb begin
		unique case (cfg.clock_select)
			tc8pwm_pkg::ClkStop:    fire = 1'b0;
			tc8pwm_pkg::ClkPinFall: fire = last_pin_q && !item.ext_pin;
			tc8pwm_pkg::ClkPinRise: fire = !last_pin_q && item.ext_pin;
			default:                fire = ((presc_q & mask) == mask);
		endcase
	end

	always_comb begin
		cnt_d      = cnt_q;
		cmp_act_d  = cmp_act_q;
		cmp_buf_d  = cmp_buf_q;
		presc_d    = presc_q;
		down_d     = down_q;
		wave_d     = wave_q;
		last_pin_d = last_pin_q;
		flags_d    = flags_q;
		en_d       = en_q;
		per_d      = per_q;
		rd         = '0;
		unique case (item.req_type)
			tc8pwm_pkg::ReqTick: begin
				presc_d    = presc_q + PW'(1);
				last_pin_d = item.ext_pin;
				if (fire) begin
					if (match)
						flags_d = flags_d | tc8pwm_pkg::FlagCmp;
					unique case (cfg.waveform_mode)
						tc8pwm_pkg::WaveNormal: begin
							cnt_d = cnt_q + CntOne;
							if (cnt_q == CntMax)
								flags_d = flags_d | tc8pwm_pkg::FlagOvf;
							if (match)
								wave_d = tc8pwm_pkg::pin_action(wave_q, cfg.output_mode);
						end
						tc8pwm_pkg::WaveCtc: begin
							if (match) begin
								cnt_d  = CntZero;
								wave_d = tc8pwm_pkg::pin_action(wave_q, cfg.output_mode);
							end else begin
								cnt_d = cnt_q + CntOne;
								if (cnt_q == CntMax)
									flags_d = flags_d | tc8pwm_pkg::FlagOvf;
							end
						end
						tc8pwm_pkg::WaveFastPwm: begin
							cnt_d = cnt_q + CntOne;
							if (match && cfg.output_mode[1])
								wave_d = tc8pwm_pkg::pin_action(wave_q, cfg.output_mode);
							if (cnt_q == CntMax) begin
								flags_d   = flags_d | tc8pwm_pkg::FlagOvf;
								cmp_act_d = cmp_buf_q;
								if (cfg.output_mode == tc8pwm_pkg::OutClear)
									wave_d = 1'b1;
								else if (cfg.output_mode == tc8pwm_pkg::OutSet)
									wave_d = 1'b0;
							end
						end
						default: begin
							if (match && cfg.output_mode[1])
								wave_d = (cfg.output_mode == tc8pwm_pkg::OutSet) ?
									rising : !rising;
							if (!down_q) begin
								if (cnt_q == CntMax) begin
									down_d    = 1'b1;
									cnt_d     = cnt_q - CntOne;
									cmp_act_d = cmp_buf_q;
								end else begin
									cnt_d = cnt_q + CntOne;
								end
							end else begin
								if (cnt_q == CntZero) begin
									down_d  = 1'b0;
									cnt_d   = CntOne;
									flags_d = flags_d | tc8pwm_pkg::FlagOvf;
								end else begin
									cnt_d = cnt_q - CntOne;
								end
							end
						end
					endcase
				end
			end
			tc8pwm_pkg::ReqWrite: begin
				unique case (item.reg_addr)
					tc8pwm_pkg::AddrCount: cnt_d = COUNT_WIDTH'(item.write_data);
					tc8pwm_pkg::AddrCompare: begin
						cmp_buf_d = COUNT_WIDTH'(item.write_data);
						if (cfg.waveform_mode == tc8pwm_pkg::WaveNormal ||
							cfg.waveform_mode == tc8pwm_pkg::WaveCtc)
							cmp_act_d = COUNT_WIDTH'(item.write_data);
					end
					tc8pwm_pkg::AddrEnables: en_d = item.write_data[1:0];
					tc8pwm_pkg::AddrFlags:   flags_d = flags_q & ~item.write_data[1:0];
					tc8pwm_pkg::AddrPeriod:  per_d = PERIOD_COUNT_WIDTH'(item.write_data);
					default: ;
				endcase
			end
			tc8pwm_pkg::ReqRead: begin
				unique case (item.reg_addr)
					tc8pwm_pkg::AddrCount:   rd = 16'(cnt_q);
					tc8pwm_pkg::AddrCompare: rd = 16'(cmp_buf_q);
					tc8pwm_pkg::AddrEnables: rd = 16'(en_q);
					tc8pwm_pkg::AddrFlags:   rd = 16'(flags_q);
					tc8pwm_pkg::AddrPeriod:  rd = per_wide[15:0];
					default:                 rd = '0;
				endcase
			end
			default: begin
				if ((item.reg_addr == tc8pwm_pkg::AckOverflow ||
					item.reg_addr == tc8pwm_pkg::AckCompare) && (flags_q & ack_bit) != 2'b00)
				begin
					flags_d = flags_q & ~ack_bit;
					if (cfg.period_tracking &&
						((cfg.waveform_mode == tc8pwm_pkg::WaveCtc) ?
						(item.reg_addr == tc8pwm_pkg::AckCompare) :
						(item.reg_addr == tc8pwm_pkg::AckOverflow)))
						per_d = per_q + PERIOD_COUNT_WIDTH'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cmp_act_q  <= '0;
			cmp_buf_q  <= '0;
			presc_q    <= '0;
			down_q     <= 1'b0;
			wave_q     <= 1'b0;
			last_pin_q <= 1'b0;
			flags_q    <= '0;
			en_q       <= '0;
			per_q      <= '0;
		end else if (step) begin
			cnt_q      <= cnt_d;
			cmp_act_q  <= cmp_act_d;
			cmp_buf_q  <= cmp_buf_d;
			presc_q    <= presc_d;
			down_q     <= down_d;
			wave_q     <= wave_d;
			last_pin_q <= last_pin_d;
			flags_q    <= flags_d;
			en_q       <= en_d;
			per_q      <= per_d;
		end
	end

	assign result.read_data = rd;
	assign result.wave_out  = (cfg.output_mode != tc8pwm_pkg::OutOff) && wave_d;
	assign result.irq       = |(flags_d & en_d);
	assign result.flags_now = flags_d;

	assign status.flags   = flags_q;
	assign status.enables = en_q;

endmodule

// File: design/timer_counter_8bit_pwm_unit.sv
// 8-bit timer/counter with pwm: one item per clock cycle while the output side
// keeps up. An accepted item (timer tick, register write, register read or
// interrupt acknowledge) sits in the input register, updates the timer state
// as it moves on and leaves its result in the output register; both registers
// move on whenever the output is free or being taken, so a new item is taken
// every cycle while the output side keeps up. Results come out in the order
// the items went in. The user must write configuration through cfg_we, cfg_index
// and cfg_wdata only while no item is in flight; the block does not enforce it.
module timer_counter_8bit_pwm_unit #(
	parameter int unsigned COUNT_WIDTH        = 8,
	parameter int unsigned PERIOD_COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tc8pwm_in_if.sink     in_ch,
	tc8pwm_out_if.source  out_ch,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [2:0]    cfg_wdata
);

	`include "timer_counter_8bit_pwm_unit_assert.svh"

	tc8pwm_pkg::cfg_t    cfg_q;
	tc8pwm_pkg::item_t   item_s1;
	tc8pwm_pkg::result_t res_s2, res_c;
	tc8pwm_pkg::status_t stat;
	logic                v_s1, v_s2, adv, take;

	assign adv         = !v_s2 || out_ch.ready;
	assign in_ch.ready = !v_s1 || adv;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tc8pwm_pkg::CfgWaveMode:   cfg_q.waveform_mode   <= cfg_wdata[1:0];
				tc8pwm_pkg::CfgOutputMode: cfg_q.output_mode     <= cfg_wdata[1:0];
				tc8pwm_pkg::CfgClockSel:   cfg_q.clock_select    <= cfg_wdata;
				default:                   cfg_q.period_tracking <= cfg_wdata[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ch.ready)
				v_s1 <= in_ch.valid;
			if (adv)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.req_type   <= in_ch.req_type;
			item_s1.reg_addr   <= in_ch.reg_addr;
			item_s1.write_data <= in_ch.write_data;
			item_s1.ext_pin    <= in_ch.ext_pin;
		end
		if (adv && v_s1)
			res_s2 <= res_c;
	end

	tc8pwm_core #(
		.COUNT_WIDTH        (COUNT_WIDTH),
		.PERIOD_COUNT_WIDTH (PERIOD_COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv && v_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_c),
		.status (stat)
	);

	assign out_ch.valid     = v_s2;
	assign out_ch.read_data = res_s2.read_data;
	assign out_ch.wave_out  = res_s2.wave_out;
	assign out_ch.irq       = res_s2.irq;
	assign out_ch.flags_now = res_s2.flags_now;

	`TC8_ASSERT_NEXT(a_s1_held, v_s1 && !adv, v_s1, "item lost from input register")
	`TC8_ASSERT_NEXT(a_s1_moves, v_s1 && adv, v_s2, "item did not reach output register")
	`TC8_ASSERT_SAME(a_flags_track, v_s2, out_ch.flags_now == stat.flags, "flags out of step")
	`TC8_ASSERT_SAME(a_irq_track, v_s2, out_ch.irq == |(stat.flags & stat.enables),
		"irq disagrees with flags and enables")

endmodule
